// File: design/ceh_pkg.sv
// Package: types, register and status codes, and the CRC-16 byte update for the entropy hash.
package ceh_pkg;

  localparam logic [15:0] CrcPoly  = 16'h100B;
  localparam logic [15:0] ByteMask = 16'h00FF;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HASH_KIND   = 2'd0,
    REG_MIN_PORT    = 2'd1,
    REG_MAX_PORT    = 2'd2,
    REG_RESULT_SIZE = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    SIZE_16 = 2'd0,
    SIZE_8  = 2'd1
  } size_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_KIND = 2'd1,
    ST_BAD_SIZE = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0]  hash_kind;
    logic [15:0] min_port;
    logic [15:0] max_port;
    logic [1:0]  result_size;
  } cfg_t;

  // One byte through the MSB-first CRC, eight shift steps.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] r;
    r = crc ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ CrcPoly;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// File: design/ceh_if.sv
// Interfaces: input byte channel and hash result channel.
interface ceh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface ceh_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] hash_value;
  logic [1:0]  status;

  modport source (output valid, output hash_value, output status, input ready);
  modport sink   (input valid, input hash_value, input status, output ready);
endinterface

// File: design/crc16_entropy_hash_unit.sv
// Top level: CRC-16 (poly 0x100B) entropy hash over byte-serial records.
// Takes one byte per cycle and keeps a running CRC-16 (poly 0x100B, MSB first,
// zero init, no final XOR) per record. Each byte is held in the input register,
// then one CRC update stage writes the remainder and, on a last byte,
// the result register, from which the hash is presented; a new byte is
// accepted in every cycle while results are taken.
// Only a result left waiting on the output stalls the input, and then only at
// the next last byte. Configuration writes belong in idle periods.
module crc16_entropy_hash_unit
  import ceh_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  ceh_in_if.sink              in_i,
  ceh_out_if.source           out_o
);

  cfg_t cfg;

  ceh_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ceh_crc_stage u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_ch  (in_i),
    .out_ch (out_o)
  );

endmodule

// File: design/ceh_cfg_regs.sv
// Configuration register file for the entropy hash.
module ceh_cfg_regs
  import ceh_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hash_kind   <= '0;
      cfg_q.min_port    <= '0;
      cfg_q.max_port    <= '1;
      cfg_q.result_size <= SIZE_16;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_HASH_KIND:   cfg_q.hash_kind   <= cfg_data_i[7:0];
        REG_MIN_PORT:    cfg_q.min_port    <= cfg_data_i;
        REG_MAX_PORT:    cfg_q.max_port    <= cfg_data_i;
        REG_RESULT_SIZE: cfg_q.result_size <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/ceh_crc_stage.sv
// Datapath: input word register, CRC update with running remainder, result register.
module ceh_crc_stage
  import ceh_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  ceh_in_if.sink    in_ch,
  ceh_out_if.source out_ch
);

  logic        in_vld_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic [15:0] rem_q;
  logic        out_vld_q;
  logic [15:0] hash_q, hash_d;
  status_e     status_q, status_d;
  logic [15:0] crc_next;
  logic        adv;

  assign adv         = in_vld_q && (!last_q || !out_vld_q || out_ch.ready);
  assign in_ch.ready = !in_vld_q || adv;
  assign crc_next    = crc_byte(rem_q, byte_q);

  always_comb begin
    hash_d   = '0;
    status_d = ST_OK;
    if (cfg_i.hash_kind != 8'd0) begin
      status_d = ST_BAD_KIND;
    end else begin
      case (cfg_i.result_size)
        SIZE_16: hash_d = (cfg_i.min_port | crc_next) & cfg_i.max_port;
        SIZE_8:  hash_d = crc_next & ByteMask;
        default: status_d = ST_BAD_SIZE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      rem_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_vld_q <= in_ch.valid;
      end
      if (adv) begin
        rem_q <= last_q ? 16'h0000 : crc_next;
      end
      if (adv && last_q) begin
        out_vld_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_q <= in_ch.data_byte;
      last_q <= in_ch.last;
    end
    if (adv && last_q) begin
      hash_q   <= hash_d;
      status_q <= status_d;
    end
  end

  assign out_ch.valid      = out_vld_q;
  assign out_ch.hash_value = hash_q;
  assign out_ch.status     = status_q;

  a_err_zero_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && status_q != ST_OK) |-> hash_q == 16'h0000)
    else $error("error result carries nonzero hash");

  a_rem_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && last_q) |=> rem_q == 16'h0000)
    else $error("remainder not cleared after last word");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !adv) |=> (in_vld_q && $stable(byte_q) && $stable(last_q)))
    else $error("stalled input word lost");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ch.ready) |-> !(adv && last_q))
    else $error("result register overwritten while stalled");

endmodule
